### rtl/dra_pkg.sv
// ----------------------------------------------------------------------------
// dra_pkg
// shared constants, codes and types of the deferred-reuse slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package dra_pkg;

   // bitmap word that the search looks at in one cycle
   localparam int CHUNK = 32;
   localparam int OFFW  = 5;

   localparam int DEFAULT_SLOT_COUNT = 256;

   localparam int FUNC_W   = 3;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_EPOCH   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_OCC = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;   // capture a new request
      logic scan;     // look at one bitmap word
      logic commit;   // apply the operation and load the result
   } dp_cmd_type;

   typedef struct packed {
      logic req_alloc;  // incoming request is an allocate
      logic scan_done;  // free slot found or whole table looked at
      logic out_free;   // result register can take a beat
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/deferred_reuse_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// deferred_reuse_slot_allocator_top
// slot index allocator with next-fit search and two-epoch quarantined reuse
// ----------------------------------------------------------------------------
// Hands out slot indices from a table of SLOT_COUNT slots. Every request beat
// gives exactly one response beat. Allocate searches next-fit from one past
// the last granted slot, wrapping, and skips slots that are occupied or in
// either quarantine; free moves an occupied slot into the current freeing
// quarantine, and it becomes usable again after two epoch advances. The
// bitmaps are searched one 32-slot word per cycle. Free, epoch advance,
// restart, clear all and unused codes go from accept straight to commit;
// allocate scans words in between, until one has a usable slot or the
// whole table has been looked at. A pending response waits in an output
// register; the next request beat is still taken, and its operation is
// applied once that register can accept the following response. Reset
// clears all bitmaps.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_reuse_slot_allocator_top #(
   parameter int SLOT_COUNT = dra_pkg::DEFAULT_SLOT_COUNT
) (
   input  wire logic         clock,
   input  wire logic         reset,

   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] slot_index
   input  wire logic [2:0]   req_tuser,   // [2:0] func

   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] granted_slot
   output logic [1:0]        rsp_tuser    // [1:0] status
);

   dra_pkg::dp_cmd_type    cmd;
   dra_pkg::dp_status_type status;

   // sequencer: accept a beat, scan words for an allocate, commit when the output is free
   dra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // bitmaps, search pointer and response register
   dra_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_func   (req_tuser),
      .req_slot   (req_tdata),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_slot   (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/dra_ctrl.sv
// ----------------------------------------------------------------------------
// dra_ctrl
// sequencer of the slot allocator: accept, word scan, commit
// ----------------------------------------------------------------------------
`default_nettype none

module dra_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire dra_pkg::dp_status_type status,
   output dra_pkg::dp_cmd_type         cmd
);

   dra_pkg::ctrl_state_type state_ff;
   dra_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dra_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.req_alloc ? dra_pkg::ST_SCAN : dra_pkg::ST_COMMIT;
            end
         end
         dra_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = dra_pkg::ST_COMMIT;
            end
         end
         dra_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               state_in = dra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dra_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         dra_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         dra_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         dra_pkg::ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/dra_dp.sv
// ----------------------------------------------------------------------------
// dra_dp
// bitmaps, word-serial next-fit search and result register
// ----------------------------------------------------------------------------
`default_nettype none

module dra_dp #(
   parameter int SLOT_COUNT = dra_pkg::DEFAULT_SLOT_COUNT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dra_pkg::dp_cmd_type           cmd,
   output dra_pkg::dp_status_type             status,
   input  wire logic [dra_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [dra_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [dra_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [dra_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int CHUNK = dra_pkg::CHUNK;
   localparam int OFFW  = dra_pkg::OFFW;
   localparam int WORDS = (SLOT_COUNT + CHUNK - 1) / CHUNK;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW    = WW + OFFW;
   localparam int SW    = $clog2(SLOT_COUNT);
   localparam int CW    = $clog2(WORDS + 1);
   localparam int CMPW  = PW + 1;
   localparam int IW    = ((PW > dra_pkg::SLOT_W) ? PW : dra_pkg::SLOT_W) + 1;

   logic [CHUNK-1:0] occ_ff [WORDS];
   logic [CHUNK-1:0] qa_ff  [WORDS];
   logic [CHUNK-1:0] qb_ff  [WORDS];
   logic             side_ff;
   logic [SW-1:0]    last_ff;
   logic             last_valid_ff;

   logic [WW-1:0]    ptr_ff;
   logic [CW-1:0]    cnt_ff;
   logic [OFFW-1:0]  off_ff;
   logic [OFFW-1:0]  bit_ff;
   logic             found_ff;
   logic             in_range_ff;
   logic [dra_pkg::FUNC_W-1:0] func_ff;

   logic                           rsp_valid_ff;
   logic [dra_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [dra_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [dra_pkg::SLOT_W-1:0]     rsp_slot_in;
   logic [dra_pkg::STATUS_W-1:0]   rsp_status_in;

   logic [CHUNK-1:0] occ_word;
   logic [CHUNK-1:0] qa_word;
   logic [CHUNK-1:0] qb_word;
   logic [CHUNK-1:0] pad_mask;
   logic [CHUNK-1:0] pass_mask;
   logic [CHUNK-1:0] avail;
   logic             hit;
   logic [OFFW-1:0]  hit_bit;
   logic             first_pass;
   logic             last_pass;
   logic [SW-1:0]    start_c;
   logic [PW-1:0]    start_p;
   logic [PW-1:0]    req_p;
   logic             req_in_range;
   logic [PW-1:0]    slot_p;
   logic             free_ok;

   assign occ_word = occ_ff[ptr_ff];
   assign qa_word  = qa_ff[ptr_ff];
   assign qb_word  = qb_ff[ptr_ff];

   assign first_pass = (cnt_ff == '0);
   assign last_pass  = (cnt_ff == CW'(WORDS));

   // slots past the table end and outside the current pass never match
   always_comb begin
      for (int b = 0; b < CHUNK; b++) begin
         pad_mask[b] = (CMPW'({ptr_ff, OFFW'(b)}) < CMPW'(SLOT_COUNT));
         if (first_pass) begin
            pass_mask[b] = (OFFW'(b) >= off_ff);
         end else if (last_pass) begin
            pass_mask[b] = (OFFW'(b) < off_ff);
         end else begin
            pass_mask[b] = 1'b1;
         end
      end
   end

   assign avail = ~(occ_word | qa_word | qb_word) & pad_mask & pass_mask;
   assign hit   = |avail;

   // lowest set bit
   always_comb begin
      hit_bit = '0;
      for (int b = CHUNK - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_bit = OFFW'(b);
         end
      end
   end

   always_comb begin
      start_c = '0;
      if (last_valid_ff) begin
         start_c = (last_ff == SW'(SLOT_COUNT - 1)) ? '0 : last_ff + 1'b1;
      end
   end

   assign start_p      = PW'(start_c);
   assign req_p        = PW'(req_slot);
   assign req_in_range = (IW'(req_slot) < IW'(SLOT_COUNT));
   assign slot_p       = {ptr_ff, bit_ff};
   assign free_ok      = in_range_ff && occ_word[bit_ff];

   assign status.req_alloc = (req_func == dra_pkg::FUNC_ALLOC);
   assign status.scan_done = hit || last_pass;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // search pointer and pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.accept) begin
         cnt_ff <= '0;
         if (req_func == dra_pkg::FUNC_ALLOC) begin
            ptr_ff <= start_p[PW-1:OFFW];
         end else if (req_in_range) begin
            ptr_ff <= req_p[PW-1:OFFW];
         end else begin
            ptr_ff <= '0;
         end
      end else if (cmd.scan && !hit && !last_pass) begin
         ptr_ff <= (ptr_ff == WW'(WORDS - 1)) ? '0 : ptr_ff + 1'b1;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff     <= req_func;
         off_ff      <= start_p[OFFW-1:0];
         bit_ff      <= req_p[OFFW-1:0];
         in_range_ff <= req_in_range;
      end else if (cmd.scan) begin
         found_ff <= hit;
         if (hit) begin
            bit_ff <= hit_bit;
         end
      end
   end

   // bitmaps and search start
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORDS; w++) begin
            occ_ff[w] <= '0;
            qa_ff[w]  <= '0;
            qb_ff[w]  <= '0;
         end
         side_ff       <= 1'b0;
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         case (func_ff)
            dra_pkg::FUNC_ALLOC: begin
               if (found_ff) begin
                  occ_ff[ptr_ff][bit_ff] <= 1'b1;
                  last_ff                <= SW'(slot_p);
                  last_valid_ff          <= 1'b1;
               end
            end
            dra_pkg::FUNC_FREE: begin
               if (free_ok) begin
                  occ_ff[ptr_ff][bit_ff] <= 1'b0;
                  if (side_ff) begin
                     qb_ff[ptr_ff][bit_ff] <= 1'b1;
                  end else begin
                     qa_ff[ptr_ff][bit_ff] <= 1'b1;
                  end
               end
            end
            dra_pkg::FUNC_EPOCH: begin
               for (int w = 0; w < WORDS; w++) begin
                  if (side_ff) begin
                     qa_ff[w] <= '0;
                  end else begin
                     qb_ff[w] <= '0;
                  end
               end
               side_ff <= !side_ff;
            end
            dra_pkg::FUNC_RESTART: begin
               last_ff       <= '0;
               last_valid_ff <= 1'b0;
            end
            dra_pkg::FUNC_CLEAR: begin
               for (int w = 0; w < WORDS; w++) begin
                  occ_ff[w] <= '0;
                  qa_ff[w]  <= '0;
                  qb_ff[w]  <= '0;
               end
               last_ff       <= '0;
               last_valid_ff <= 1'b0;
            end
            default: begin
               last_valid_ff <= last_valid_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_slot_in   = '0;
      rsp_status_in = dra_pkg::STATUS_OK;
      case (func_ff)
         dra_pkg::FUNC_ALLOC: begin
            if (found_ff) begin
               rsp_slot_in = dra_pkg::SLOT_W'(slot_p);
            end else begin
               rsp_status_in = dra_pkg::STATUS_FULL;
            end
         end
         dra_pkg::FUNC_FREE: begin
            if (!free_ok) begin
               rsp_status_in = dra_pkg::STATUS_NOT_OCC;
            end
         end
         default: begin
            rsp_status_in = dra_pkg::STATUS_OK;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(WORDS))
      else $error("search ran past one full pass");

   a_ptr_bound : assert property (@(posedge clock) disable iff (reset)
      (WW + 1)'(ptr_ff) < (WW + 1)'(WORDS))
      else $error("search pointer outside bitmap");

   a_rsp_from_commit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result beat without a commit");

   a_grant_sets_last : assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && func_ff == dra_pkg::FUNC_ALLOC && found_ff) |=> last_valid_ff)
      else $error("grant did not record the search start");

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the deferred-reuse slot allocator
// ----------------------------------------------------------------------------
// Requests are queued up front by a generator that tracks the slot table, so
// frees can target slots that are really held. A driver sends them with
// random gaps. Each accepted beat updates a second copy of the table that
// predicts the response. A monitor compares the responses in order while the
// receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = dra_pkg::DEFAULT_SLOT_COUNT;
   localparam int FUNC_W       = dra_pkg::FUNC_W;
   localparam int SLOT_W       = dra_pkg::SLOT_W;
   localparam int STATUS_W     = dra_pkg::STATUS_W;
   localparam int TOTAL_ITEMS  = 1300;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_MAX   = 10;

   // slot table as the block keeps it
   typedef struct packed {
      logic [SLOTS-1:0]  occ;
      logic [SLOTS-1:0]  qa;
      logic [SLOTS-1:0]  qb;
      logic              side_b;     // quarantine b is the freeing side
      logic [SLOT_W-1:0] last_slot;
      logic              last_ok;
   } slot_table_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } grant_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot;
      logic              hold;       // wait for all responses before sending
   } request_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic [2:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;
   logic [1:0]          rsp_tuser;

   request_type         requests_todo[$];
   grant_type           grants_due[$];
   slot_table_type      plan_table;      // table as seen by the generator
   slot_table_type      live_table;      // table as seen at accepted beats
   int                  item_count;
   int                  error_count;
   int                  rsp_count;
   int                  cycle_count;
   logic                req_beat_taken;
   int                  send_gap;
   int                  stall_left;
   logic                send_calm;
   logic                recv_calm;

   deferred_reuse_slot_allocator_top #(
      .SLOT_COUNT(SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // table update for one request, returns the response it causes
   // ---------------------------------------------------------------------
   function automatic grant_type table_step(inout slot_table_type t,
                                            input logic [FUNC_W-1:0] fn,
                                            input logic [SLOT_W-1:0] idx);
      grant_type         r;
      logic [SLOT_W-1:0] pos;
      logic              found;
      r.slot   = '0;
      r.status = dra_pkg::STATUS_OK;
      case (fn)
         dra_pkg::FUNC_ALLOC: begin
            // next-fit: one past the last grant, or slot 0 after restart
            pos   = t.last_ok ? SLOT_W'(t.last_slot + 1'b1) : '0;
            found = 1'b0;
            for (int n = 0; n < SLOTS; n++) begin
               if (!found) begin
                  if (!(t.occ[pos] || t.qa[pos] || t.qb[pos]))
                     found = 1'b1;
                  else
                     pos = pos + 1'b1;
               end
            end
            if (found) begin
               t.occ[pos]  = 1'b1;
               t.last_slot = pos;
               t.last_ok   = 1'b1;
               r.slot      = pos;
            end else begin
               r.status = dra_pkg::STATUS_FULL;
            end
         end
         dra_pkg::FUNC_FREE: begin
            if (t.occ[idx]) begin
               t.occ[idx] = 1'b0;
               if (t.side_b)
                  t.qb[idx] = 1'b1;
               else
                  t.qa[idx] = 1'b1;
            end else begin
               r.status = dra_pkg::STATUS_NOT_OCC;
            end
         end
         dra_pkg::FUNC_EPOCH: begin
            // waiting side is released, then the roles swap
            if (t.side_b)
               t.qa = '0;
            else
               t.qb = '0;
            t.side_b = ~t.side_b;
         end
         dra_pkg::FUNC_RESTART: begin
            t.last_slot = '0;
            t.last_ok   = 1'b0;
         end
         dra_pkg::FUNC_CLEAR: begin
            t.occ       = '0;
            t.qa        = '0;
            t.qb        = '0;
            t.last_slot = '0;
            t.last_ok   = 1'b0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap(logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 40);
   endfunction

   // some slot that is occupied right now, or any slot when none is
   function automatic logic [SLOT_W-1:0] pick_busy(slot_table_type t);
      logic [SLOT_W-1:0] start;
      logic [SLOT_W-1:0] pos;
      start = SLOT_W'($urandom);
      for (int n = 0; n < SLOTS; n++) begin
         pos = SLOT_W'(start + n);
         if (t.occ[pos])
            return pos;
      end
      return start;
   endfunction

   task automatic queue_req(logic [FUNC_W-1:0] fn, logic [SLOT_W-1:0] idx, logic hold);
      request_type rq;
      grant_type   unused_grant;
      rq.func = fn;
      rq.slot = idx;
      rq.hold = hold;
      requests_todo.push_back(rq);
      unused_grant = table_step(plan_table, fn, idx);
      // codes past clear all do nothing and do not count
      if (fn <= dra_pkg::FUNC_CLEAR)
         item_count++;
   endtask

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      int                pick;
      int                burst;
      logic [SLOT_W-1:0] idx;
      plan_table  = '0;
      live_table  = '0;
      item_count  = 0;
      error_count = 0;
      rsp_count   = 0;

      // directed opening: first grants, frees, quarantine aging, odd codes
      queue_req(dra_pkg::FUNC_ALLOC,   8'h00, 1'b0);   // empty table grants slot 0
      queue_req(dra_pkg::FUNC_ALLOC,   8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_FREE,    8'h00, 1'b0);   // slot 0 goes to quarantine a
      queue_req(dra_pkg::FUNC_FREE,    8'h00, 1'b0);   // already free
      queue_req(dra_pkg::FUNC_FREE,    8'hff, 1'b0);   // never held
      queue_req(dra_pkg::FUNC_ALLOC,   8'hff, 1'b0);
      queue_req(dra_pkg::FUNC_RESTART, 8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_ALLOC,   8'h00, 1'b0);   // search from 0 skips quarantine
      queue_req(dra_pkg::FUNC_EPOCH,   8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_RESTART, 8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_ALLOC,   8'h00, 1'b0);   // one advance is not enough
      queue_req(dra_pkg::FUNC_EPOCH,   8'h00, 1'b1);   // pause until all answered
      queue_req(dra_pkg::FUNC_RESTART, 8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_ALLOC,   8'h00, 1'b0);   // slot 0 is back after two
      queue_req(dra_pkg::FUNC_FREE,    8'h01, 1'b0);   // freed on side a
      queue_req(dra_pkg::FUNC_CLEAR + 3'd1, 8'haa, 1'b0);
      queue_req(dra_pkg::FUNC_CLEAR + 3'd2, 8'h55, 1'b0);
      queue_req(dra_pkg::FUNC_CLEAR + 3'd3, 8'hff, 1'b0);
      queue_req(dra_pkg::FUNC_CLEAR,   8'h00, 1'b0);   // side stays a across clear
      queue_req(dra_pkg::FUNC_ALLOC,   8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_FREE,    8'h00, 1'b0);
      queue_req(dra_pkg::FUNC_EPOCH,   8'h00, 1'b0);

      // fill the table up so the full case is seen early, then wrap
      burst = SLOTS - $countones(plan_table.occ | plan_table.qa | plan_table.qb) + 2;
      for (int n = 0; n < burst; n++)
         queue_req(dra_pkg::FUNC_ALLOC, SLOT_W'($urandom), n == 0);

      while (item_count < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            burst = $urandom_range(1, 24);
            for (int n = 0; n < burst; n++)
               queue_req(dra_pkg::FUNC_ALLOC, SLOT_W'($urandom),
                         $urandom_range(0, 149) == 0);
         end else if (pick < 60) begin
            burst = $urandom_range(1, 8);
            for (int n = 0; n < burst; n++) begin
               idx = ($urandom_range(0, 99) < 85) ? pick_busy(plan_table)
                                                  : SLOT_W'($urandom);
               queue_req(dra_pkg::FUNC_FREE, idx, $urandom_range(0, 149) == 0);
            end
         end else if (pick < 70) begin
            queue_req(dra_pkg::FUNC_EPOCH, SLOT_W'($urandom), 1'b0);
         end else if (pick < 75) begin
            queue_req(dra_pkg::FUNC_RESTART, SLOT_W'($urandom), 1'b0);
         end else if (pick < 78) begin
            queue_req(dra_pkg::FUNC_CLEAR, SLOT_W'($urandom), 1'b0);
         end else if (pick < 82) begin
            queue_req(dra_pkg::FUNC_CLEAR + FUNC_W'($urandom_range(1, 3)),
                      SLOT_W'($urandom), 1'b0);
         end else if (pick < 84) begin
            // run into a full table again
            burst = SLOTS - $countones(plan_table.occ | plan_table.qa | plan_table.qb)
                    + $urandom_range(1, 3);
            for (int n = 0; n < burst; n++)
               queue_req(dra_pkg::FUNC_ALLOC, SLOT_W'($urandom), 1'b0);
         end else begin
            queue_req(FUNC_W'($urandom_range(0, 7)), SLOT_W'($urandom), 1'b0);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // everything sent, everything answered, then a quiet stretch
      while (requests_todo.size() != 0 || req_tvalid || grants_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // request side: note accepted beats and predict their responses
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_beat_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         grants_due.push_back(table_step(live_table, req_tuser, req_tdata));
         req_beat_taken = 1'b1;
      end
   end

   // driver: a new beat only once the current one has been taken
   always @(negedge clock) begin
      request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap    = 0;
         send_calm   = 1'b0;
      end else begin
         // switch between calm stretches and gappy ones now and then
         if ($urandom_range(0, 199) == 0)
            send_calm = ~send_calm;
         if (!req_tvalid || req_beat_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (requests_todo.size() != 0 &&
                         !(requests_todo[0].hold && grants_due.size() != 0)) begin
               rq = requests_todo.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= rq.func;
               req_tdata  <= rq.slot;
               send_gap    = pick_gap(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response side: random back-pressure and in-order compare
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
         recv_calm   = 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0)
            recv_calm = ~recv_calm;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left  = pick_gap(recv_calm);
         end
      end
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grants_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("beat %0d: response slot %0d status %0d with none outstanding",
                        rsp_count, rsp_tdata, rsp_tuser);
         end else begin
            want = grants_due.pop_front();
            if (rsp_tdata !== want.slot || rsp_tuser !== want.status) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("beat %0d: expected slot %0d status %0d, got slot %0d status %0d",
                           rsp_count, want.slot, want.status, rsp_tdata, rsp_tuser);
            end
         end
         rsp_count++;
      end
   end

   // hang guard
   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

`default_nettype wire

### files.f
rtl/dra_pkg.sv
rtl/dra_ctrl.sv
rtl/dra_dp.sv
rtl/deferred_reuse_slot_allocator_top.sv
dv/testbench.sv
